FILE: hdl/fprs_pkg.sv
// fprs_pkg: shared types and constants of the flit receive and scatter core.
// Used by fprs_front, fprs_queue, fprs_back and the top level. No dependencies.
`timescale 1ns / 1ps

package fprs_pkg;

  // Store geometry and chunk limits
  localparam int MAX_ELEMENTS = 1048576;
  localparam int ADDR_SPAN    = 1048576;
  localparam int STORE_BOUND  = (MAX_ELEMENTS < ADDR_SPAN) ? MAX_ELEMENTS : ADDR_SPAN;
  localparam int MAX_CHUNKS   = 256;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [23:0] COUNT_MAX  = 24'h00FFFFFF;
  localparam logic [20:0] BASE_MAX   = 21'h1FFFFF;
  localparam logic [8:0]  CHUNK_SAT  = 9'h1FF;
  localparam logic [16:0] SPATIAL_RST = 17'd36;  // 6 * 6 pooled input

  // Register word indices (taken from address bits 3:2)
  localparam logic [1:0] REG_LAYOUT   = 2'd0;
  localparam logic [1:0] REG_SPATIAL  = 2'd1;
  localparam logic [1:0] REG_TENSOR   = 2'd2;
  localparam logic [1:0] REG_EXPECTED = 2'd3;

  typedef enum logic [1:0] {
    CODE_HEAD = 2'd0,
    CODE_BODY = 2'd1,
    CODE_TAIL = 2'd2,
    CODE_SKIP = 2'd3
  } flit_code_e;

  typedef enum logic [3:0] {
    PT_DATA   = 4'd0,
    PT_WEIGHT = 4'd1,
    PT_BIAS   = 4'd2,
    PT_RESULT = 4'd3
  } pkt_type_e;

  typedef enum logic [1:0] {
    TGT_INPUT  = 2'd0,
    TGT_WEIGHT = 2'd1,
    TGT_BIAS   = 2'd2
  } target_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BODY_IDLE = 3'd1,
    ERR_TAIL_IDLE = 3'd2,
    ERR_UNKNOWN   = 3'd3,
    ERR_OVERFLOW  = 3'd4
  } err_e;

  typedef struct packed {
    logic        layout_mode;
    logic [16:0] spatial_size;
    logic [20:0] tensor_size;
    logic [8:0]  expected_chunks;
  } cfg_t;

  // Finished result beat
  typedef struct packed {
    logic        wv;
    target_e     wt;
    logic [19:0] wa;
    logic [31:0] wd;
    logic        wl;
    logic        bl;
    logic        ic;
    err_e        err;
  } res_t;

  // Classified flit handed from front to back
  typedef struct packed {
    res_t        res;      // complete unless scatter is set
    logic        scatter;  // result body that still needs address resolution
    logic        mode;
    logic [23:0] j;
    logic [20:0] base;
    logic [20:0] limit;
    logic [16:0] sp;
    logic [20:0] bound;
  } ent_t;

endpackage

FILE: hdl/fprs_front.sv
// fprs_front: packet state tracker and flit classifier.
// Depends on fprs_pkg.
`timescale 1ns / 1ps

module fprs_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [1:0]      flit_code_i,
  input  logic [31:0]     flit_bits_i,
  input  fprs_pkg::cfg_t  cfg_i,
  output fprs_pkg::ent_t  ent_o
);

  logic        in_packet_q,   in_packet_d;
  logic [3:0]  packet_kind_q, packet_kind_d;
  logic [23:0] body_cnt_q,    body_cnt_d;
  logic [20:0] chunk_base_q,  chunk_base_d;
  logic [20:0] chunk_limit_q, chunk_limit_d;
  logic [8:0]  chunks_q,      chunks_d;

  logic [16:0] sp_eff;
  logic [20:0] bound;
  logic [8:0]  need;
  logic [8:0]  chunks_inc;
  logic [20:0] f2i_val;

  // Truncate a float word to a non-negative index, saturating at BASE_MAX
  function automatic logic [20:0] f2i(input logic [31:0] w);
    logic [7:0]  e;
    logic [22:0] m;
    logic [7:0]  sh;
    logic [23:0] sig;
    logic [20:0] r;
    e   = w[30:23];
    m   = w[22:0];
    sh  = e - 8'd127;
    sig = {1'b1, m};
    r   = '0;
    if (e == 8'hFF) begin
      r = ((m != '0) || w[31]) ? 21'd0 : fprs_pkg::BASE_MAX;
    end else if ((e < 8'd127) || w[31]) begin
      r = 21'd0;
    end else if (sh >= 8'd21) begin
      r = fprs_pkg::BASE_MAX;
    end else begin
      r = 21'(sig >> (5'd23 - sh[4:0]));
    end
    return r;
  endfunction

  // Derived configuration values
  always_comb begin
    sp_eff = (cfg_i.spatial_size == '0) ? 17'd1 : cfg_i.spatial_size;
    bound  = ({11'd0, cfg_i.tensor_size} < 32'(fprs_pkg::STORE_BOUND)) ?
             cfg_i.tensor_size : 21'(fprs_pkg::STORE_BOUND);
    if (cfg_i.expected_chunks == '0) begin
      need = 9'd1;
    end else if ({23'd0, cfg_i.expected_chunks} > 32'(fprs_pkg::MAX_CHUNKS)) begin
      need = 9'(fprs_pkg::MAX_CHUNKS);
    end else begin
      need = cfg_i.expected_chunks;
    end
    chunks_inc = (chunks_q < fprs_pkg::CHUNK_SAT) ? chunks_q + 9'd1 : chunks_q;
    f2i_val    = f2i(flit_bits_i);
  end

  // Classify the flit and compute next packet state
  always_comb begin
    in_packet_d   = in_packet_q;
    packet_kind_d = packet_kind_q;
    body_cnt_d    = body_cnt_q;
    chunk_base_d  = chunk_base_q;
    chunk_limit_d = chunk_limit_q;
    chunks_d      = chunks_q;

    ent_o         = '0;
    ent_o.res.wt  = fprs_pkg::TGT_INPUT;
    ent_o.res.err = fprs_pkg::ERR_NONE;
    ent_o.res.wd  = flit_bits_i;
    ent_o.mode    = cfg_i.layout_mode;
    ent_o.j       = body_cnt_q - 24'd2;
    ent_o.base    = chunk_base_q;
    ent_o.limit   = chunk_limit_q;
    ent_o.sp      = sp_eff;
    ent_o.bound   = bound;

    case (flit_code_i)
      fprs_pkg::CODE_HEAD: begin
        in_packet_d   = 1'b1;
        packet_kind_d = flit_bits_i[27:24];
        body_cnt_d    = '0;
        chunk_base_d  = '0;
        chunk_limit_d = '0;
      end
      fprs_pkg::CODE_BODY: begin
        if (!in_packet_q) begin
          ent_o.res.err = fprs_pkg::ERR_BODY_IDLE;
        end else begin
          if (packet_kind_q == fprs_pkg::PT_DATA || packet_kind_q == fprs_pkg::PT_WEIGHT ||
              packet_kind_q == fprs_pkg::PT_BIAS) begin
            if ({8'd0, body_cnt_q} < 32'(fprs_pkg::STORE_BOUND)) begin
              ent_o.res.wv = 1'b1;
              ent_o.res.wt = fprs_pkg::target_e'(packet_kind_q[1:0]);
              ent_o.res.wa = body_cnt_q[19:0];
            end else begin
              ent_o.res.err = fprs_pkg::ERR_OVERFLOW;
            end
          end else if (packet_kind_q == fprs_pkg::PT_RESULT) begin
            if (body_cnt_q == 24'd0) begin
              chunk_base_d = f2i_val;
            end else if (body_cnt_q == 24'd1) begin
              chunk_limit_d = f2i_val;
            end else begin
              ent_o.scatter = 1'b1;
            end
          end
          if (body_cnt_q < fprs_pkg::COUNT_MAX) begin
            body_cnt_d = body_cnt_q + 24'd1;
          end
        end
      end
      fprs_pkg::CODE_TAIL: begin
        if (!in_packet_q) begin
          ent_o.res.err = fprs_pkg::ERR_TAIL_IDLE;
        end else begin
          case (packet_kind_q)
            fprs_pkg::PT_DATA: begin
              ent_o.res.ic = 1'b1;
              chunks_d     = '0;
            end
            fprs_pkg::PT_WEIGHT: ent_o.res.wl = 1'b1;
            fprs_pkg::PT_BIAS:   ent_o.res.bl = 1'b1;
            fprs_pkg::PT_RESULT: begin
              if (body_cnt_q >= 24'd2) begin
                chunks_d = chunks_inc;
                if (chunks_inc >= need) begin
                  ent_o.res.ic = 1'b1;
                  chunks_d     = '0;
                end
              end
            end
            default: ent_o.res.err = fprs_pkg::ERR_UNKNOWN;
          endcase
          in_packet_d   = 1'b0;
          packet_kind_d = '0;
          body_cnt_d    = '0;
          chunk_base_d  = '0;
          chunk_limit_d = '0;
        end
      end
      default: begin
        // ignored flit: no state change, empty result
      end
    endcase
    // Payload of a non-writing beat reads as zero
    if (!ent_o.res.wv && !ent_o.scatter) begin
      ent_o.res.wd = '0;
    end
  end

  // Advance packet state on every accepted flit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q   <= 1'b0;
      packet_kind_q <= '0;
      body_cnt_q    <= '0;
      chunk_base_q  <= '0;
      chunk_limit_q <= '0;
      chunks_q      <= '0;
    end else if (accept_i) begin
      in_packet_q   <= in_packet_d;
      packet_kind_q <= packet_kind_d;
      body_cnt_q    <= body_cnt_d;
      chunk_base_q  <= chunk_base_d;
      chunk_limit_q <= chunk_limit_d;
      chunks_q      <= chunks_d;
    end
  end

endmodule

FILE: hdl/fprs_queue.sv
// fprs_queue: short FIFO of classified flits between front and back.
// Depends on fprs_pkg.
`timescale 1ns / 1ps

module fprs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fprs_pkg::ent_t  push_data_i,
  output logic            full_o,
  output logic            valid_o,
  output fprs_pkg::ent_t  head_o,
  input  logic            pop_i
);

  localparam int PW = (fprs_pkg::QUEUE_DEPTH > 1) ? $clog2(fprs_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(fprs_pkg::QUEUE_DEPTH + 1);

  fprs_pkg::ent_t mem_q [fprs_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  count_q;

  assign full_o  = (count_q == CW'(fprs_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(fprs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(fprs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: hdl/fprs_back.sv
// fprs_back: scatter address resolution and result output register.
// Depends on fprs_pkg; fed by fprs_queue.
`timescale 1ns / 1ps

module fprs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  fprs_pkg::ent_t  q_head_i,
  output logic            q_pop_o,
  output logic            res_valid_o,
  input  logic            res_stall_i,
  output fprs_pkg::res_t  res_o
);

  // Product stage
  logic           s1_v_q;
  fprs_pkg::ent_t s1_ent_q;
  logic [37:0]    s1_pb_q;
  logic [37:0]    s1_pl_q;
  // Output stage
  logic           out_v_q;
  fprs_pkg::res_t out_q, out_d;

  logic        out_ready, s1_ready;
  logic [37:0] lim_ext, base_ext;
  logic [38:0] dst;
  logic        in_range;

  assign out_ready = !out_v_q || !res_stall_i;
  assign s1_ready  = !s1_v_q || out_ready;
  assign q_pop_o   = q_valid_i && s1_ready;

  // Scale chunk start and count by the spatial size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_ent_q <= q_head_i;
      s1_pb_q  <= q_head_i.base * q_head_i.sp;
      s1_pl_q  <= q_head_i.limit * q_head_i.sp;
    end
  end

  // Check bounds and form the scatter write
  always_comb begin
    lim_ext  = s1_ent_q.mode ? {17'd0, s1_ent_q.limit} : s1_pl_q;
    base_ext = s1_ent_q.mode ? {17'd0, s1_ent_q.base}  : s1_pb_q;
    dst      = {1'b0, base_ext} + {15'd0, s1_ent_q.j};
    in_range = ({14'd0, s1_ent_q.j} < lim_ext) && (dst < {18'd0, s1_ent_q.bound});
    out_d    = s1_ent_q.res;
    if (s1_ent_q.scatter) begin
      if (in_range) begin
        out_d.wv = 1'b1;
        out_d.wt = fprs_pkg::TGT_INPUT;
        out_d.wa = dst[19:0];
      end else begin
        out_d.wd  = '0;
        out_d.err = fprs_pkg::ERR_OVERFLOW;
      end
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_v_q) begin
      out_q <= out_d;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  // A write beat never carries an error code
  a_write_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.wv) |-> (out_q.err == fprs_pkg::ERR_NONE))
    else $error("write beat with error code");

  // Weight and bias loaded never pulse together
  a_loaded_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !(out_q.wl && out_q.bl))
    else $error("weight and bias loaded together");

  // Product stage holds while the output register is blocked
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !out_ready) |=> (s1_v_q && $stable(s1_pb_q) && $stable(s1_pl_q)))
    else $error("product stage changed under stall");

  // A scatter write stays below the store span
  a_scatter_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s1_ent_q.scatter && in_range) |-> (dst[38:20] == '0))
    else $error("scatter address beyond store span");

endmodule

FILE: hdl/flit_packet_receive_and_scatter_core.sv
// flit_packet_receive_and_scatter_core: top level with APB register file.
// Depends on fprs_pkg, fprs_front, fprs_queue and fprs_back.
`timescale 1ns / 1ps

// Takes one flit per cycle while flit_stall_o is low and returns exactly one
// result beat per flit, in order. An accepted flit passes the queue write,
// then a product stage that scales chunk start and count by the spatial size,
// then the output register, before its result beat is shown. A two-entry
// queue separates the packet tracker from the scatter pipeline, so flits keep
// being accepted while a result waits on res_stall_i; flit_stall_o rises only
// when that queue is full. Registers (APB, 4-byte stride): 0 layout_mode,
// 1 spatial_size, 2 tensor_size, 3 expected_chunks.
// Write them only while no flit is in flight.
module flit_packet_receive_and_scatter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Flit input
  input  logic        flit_valid_i,
  output logic        flit_stall_o,
  input  logic [1:0]  flit_code_i,
  input  logic [31:0] flit_bits_i,
  // Result output
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic        write_valid_o,
  output logic [1:0]  write_target_o,
  output logic [19:0] write_address_o,
  output logic [31:0] write_data_o,
  output logic        weight_loaded_o,
  output logic        bias_loaded_o,
  output logic        input_complete_o,
  output logic [2:0]  error_code_o
);

  fprs_pkg::cfg_t cfg_q;
  fprs_pkg::ent_t front_ent, q_head;
  fprs_pkg::res_t res;
  logic           q_full, q_valid, q_pop;
  logic           flit_accept;
  logic           cfg_wr;

  // Register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.layout_mode     <= 1'b0;
      cfg_q.spatial_size    <= fprs_pkg::SPATIAL_RST;
      cfg_q.tensor_size     <= '0;
      cfg_q.expected_chunks <= 9'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        fprs_pkg::REG_LAYOUT:   cfg_q.layout_mode     <= pwdata[0];
        fprs_pkg::REG_SPATIAL:  cfg_q.spatial_size    <= pwdata[16:0];
        fprs_pkg::REG_TENSOR:   cfg_q.tensor_size     <= pwdata[20:0];
        fprs_pkg::REG_EXPECTED: cfg_q.expected_chunks <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fprs_pkg::REG_LAYOUT:   prdata = {31'd0, cfg_q.layout_mode};
      fprs_pkg::REG_SPATIAL:  prdata = {15'd0, cfg_q.spatial_size};
      fprs_pkg::REG_TENSOR:   prdata = {11'd0, cfg_q.tensor_size};
      fprs_pkg::REG_EXPECTED: prdata = {23'd0, cfg_q.expected_chunks};
      default:                prdata = '0;
    endcase
  end

  // Accept a flit whenever the queue has room
  assign flit_stall_o = q_full;
  assign flit_accept  = flit_valid_i && !q_full;

  fprs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (flit_accept),
    .flit_code_i (flit_code_i),
    .flit_bits_i (flit_bits_i),
    .cfg_i       (cfg_q),
    .ent_o       (front_ent)
  );

  fprs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (flit_accept),
    .push_data_i (front_ent),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head),
    .pop_i       (q_pop)
  );

  fprs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .res_o       (res)
  );

  // Drive result fields
  assign write_valid_o    = res.wv;
  assign write_target_o   = res.wt;
  assign write_address_o  = res.wa;
  assign write_data_o     = res.wd;
  assign weight_loaded_o  = res.wl;
  assign bias_loaded_o    = res.bl;
  assign input_complete_o = res.ic;
  assign error_code_o     = res.err;

endmodule

FILE: tb/sv/tb_fprs_checker.sv
// tb_fprs_checker: watches the flit, result and register channels of the core,
// predicts one result beat per accepted flit and compares it with the block.
// Depends on fprs_pkg for the type, target, error and register codes.
`timescale 1ns / 1ps

module tb_fprs_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Register port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  // Flit channel
  input  logic        flit_valid_i,
  input  logic        flit_stall_i,
  input  logic [1:0]  flit_code_i,
  input  logic [31:0] flit_bits_i,
  // Result channel
  input  logic        res_valid_i,
  input  logic        res_stall_i,
  input  logic        write_valid_i,
  input  logic [1:0]  write_target_i,
  input  logic [19:0] write_address_i,
  input  logic [31:0] write_data_i,
  input  logic        weight_loaded_i,
  input  logic        bias_loaded_i,
  input  logic        input_complete_i,
  input  logic [2:0]  error_code_i,
  // Status for the test top
  output int          fail_count_o,
  output int          pending_o
);

  // Shadow registers
  logic        cfg_flat;
  logic [16:0] cfg_spatial;
  logic [20:0] cfg_tensor;
  logic [8:0]  cfg_chunks;

  // Packet tracking state
  logic        pkt_open;
  logic [3:0]  pkt_type;
  logic [23:0] body_count;
  logic [20:0] chunk_start;
  logic [20:0] chunk_count;
  logic [8:0]  chunks_seen;

  fprs_pkg::res_t write_beats_due[$];
  fprs_pkg::res_t due_beat;
  int             mismatches = 0;

  // Truncate a float word to a chunk index; clamp negatives and NaN to 0.
  function automatic logic [20:0] float_index(input logic [31:0] w);
    logic [7:0]  e;
    logic [22:0] m;
    int unsigned sh;
    e = w[30:23];
    m = w[22:0];
    if (e == 8'hFF) begin
      if (m != 0 || w[31]) return '0;
      return fprs_pkg::BASE_MAX;
    end
    if (e < 8'd127 || w[31]) return '0;
    sh = e - 127;
    if (sh >= 21) return fprs_pkg::BASE_MAX;
    return 21'({1'b1, m} >> (23 - sh));
  endfunction

  // Advance the packet state by one flit and return the beat it produces.
  function automatic fprs_pkg::res_t scatter_flit(input logic [1:0] kind,
                                                  input logic [31:0] bits);
    fprs_pkg::res_t  r;
    longint unsigned j, sp, offs, dst, bound;
    logic [8:0]      need;
    r = '0;
    case (kind)
      fprs_pkg::CODE_HEAD: begin
        // a head inside a packet drops the open one
        pkt_open    = 1'b1;
        pkt_type    = bits[27:24];
        body_count  = '0;
        chunk_start = '0;
        chunk_count = '0;
      end
      fprs_pkg::CODE_BODY: begin
        if (!pkt_open) begin
          r.err = fprs_pkg::ERR_BODY_IDLE;
        end else begin
          if (pkt_type <= fprs_pkg::PT_BIAS) begin
            if (body_count < fprs_pkg::STORE_BOUND) begin
              r.wv = 1'b1;
              r.wt = fprs_pkg::target_e'(pkt_type[1:0]);
              r.wa = body_count[19:0];
              r.wd = bits;
            end else begin
              r.err = fprs_pkg::ERR_OVERFLOW;
            end
          end else if (pkt_type == fprs_pkg::PT_RESULT) begin
            if (body_count == 0) begin
              chunk_start = float_index(bits);
            end else if (body_count == 1) begin
              chunk_count = float_index(bits);
            end else begin
              j  = body_count - 2;
              sp = (cfg_spatial == 0) ? 1 : cfg_spatial;
              if (cfg_flat) begin
                offs = j;
                dst  = chunk_start + j;
              end else begin
                offs = j / sp;
                dst  = chunk_start * sp + j;
              end
              bound = fprs_pkg::STORE_BOUND;
              if (cfg_tensor < bound) bound = cfg_tensor;
              if (offs < chunk_count && dst < bound) begin
                r.wv = 1'b1;
                r.wt = fprs_pkg::TGT_INPUT;
                r.wa = dst[19:0];
                r.wd = bits;
              end else begin
                r.err = fprs_pkg::ERR_OVERFLOW;
              end
            end
          end
          // saturate the body counter
          if (body_count < fprs_pkg::COUNT_MAX) body_count++;
        end
      end
      fprs_pkg::CODE_TAIL: begin
        if (!pkt_open) begin
          r.err = fprs_pkg::ERR_TAIL_IDLE;
        end else begin
          case (pkt_type)
            fprs_pkg::PT_DATA: begin
              r.ic        = 1'b1;
              chunks_seen = '0;
            end
            fprs_pkg::PT_WEIGHT: r.wl = 1'b1;
            fprs_pkg::PT_BIAS:   r.bl = 1'b1;
            fprs_pkg::PT_RESULT: begin
              // short result packets do not count as a chunk
              if (body_count >= 2) begin
                need = (cfg_chunks == 0) ? 9'd1 : cfg_chunks;
                if (need > fprs_pkg::MAX_CHUNKS) need = 9'(fprs_pkg::MAX_CHUNKS);
                if (chunks_seen < fprs_pkg::CHUNK_SAT) chunks_seen++;
                if (chunks_seen >= need) begin
                  r.ic        = 1'b1;
                  chunks_seen = '0;
                end
              end
            end
            default: r.err = fprs_pkg::ERR_UNKNOWN;
          endcase
          pkt_open    = 1'b0;
          pkt_type    = '0;
          body_count  = '0;
          chunk_start = '0;
          chunk_count = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_flat    = 1'b0;
      cfg_spatial = fprs_pkg::SPATIAL_RST;
      cfg_tensor  = '0;
      cfg_chunks  = 9'd1;
      pkt_open    = 1'b0;
      pkt_type    = '0;
      body_count  = '0;
      chunk_start = '0;
      chunk_count = '0;
      chunks_seen = '0;
      write_beats_due.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      // Compare the result beat with the oldest prediction
      if (res_valid_i && !res_stall_i) begin
        if (write_beats_due.size() == 0) begin
          $display("%0t: result beat with no prediction waiting", $time);
          mismatches++;
        end else begin
          due_beat = write_beats_due.pop_front();
          check_field("write_valid",    due_beat.wv,  write_valid_i);
          check_field("write_target",   due_beat.wt,  write_target_i);
          check_field("write_address",  due_beat.wa,  write_address_i);
          check_field("write_data",     due_beat.wd,  write_data_i);
          check_field("weight_loaded",  due_beat.wl,  weight_loaded_i);
          check_field("bias_loaded",    due_beat.bl,  bias_loaded_i);
          check_field("input_complete", due_beat.ic,  input_complete_i);
          check_field("error_code",     due_beat.err, error_code_i);
        end
      end
      // Predict the beat for an accepted flit
      if (flit_valid_i && !flit_stall_i)
        write_beats_due.insert(write_beats_due.size(),
                               scatter_flit(flit_code_i, flit_bits_i));
      // Track register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          fprs_pkg::REG_LAYOUT:   cfg_flat    = pwdata_i[0];
          fprs_pkg::REG_SPATIAL:  cfg_spatial = pwdata_i[16:0];
          fprs_pkg::REG_TENSOR:   cfg_tensor  = pwdata_i[20:0];
          fprs_pkg::REG_EXPECTED: cfg_chunks  = pwdata_i[8:0];
          default: ;
        endcase
      end
      pending_o    <= write_beats_due.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

FILE: tb/sv/tb_flit_packet_receive_and_scatter_core.sv
// tb_flit_packet_receive_and_scatter_core: drives flits and register writes into
// the core and gives the verdict. Depends on fprs_pkg, the core and tb_fprs_checker.
`timescale 1ns / 1ps

module tb_flit_packet_receive_and_scatter_core;

  localparam int QUIET_LIMIT = 1000;
  localparam int PHASE_ITEMS = 115;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [3:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        flit_valid = 1'b0;
  logic        flit_stall;
  logic [1:0]  flit_code  = fprs_pkg::CODE_SKIP;
  logic [31:0] flit_bits  = '0;
  logic        res_valid;
  logic        res_stall  = 1'b0;
  logic        write_valid;
  logic [1:0]  write_target;
  logic [19:0] write_address;
  logic [31:0] write_data;
  logic        weight_loaded;
  logic        bias_loaded;
  logic        input_complete;
  logic [2:0]  error_code;

  int fail_count;
  int pending;

  bit          tx_idle     = 1'b1;
  bit          rx_idle     = 1'b1;
  bit          hold_long   = 1'b0;
  int          flits_sent  = 0;
  bit          cur_flat    = 1'b0;
  int unsigned cur_spatial = 36;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  flit_packet_receive_and_scatter_core u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .flit_valid_i     (flit_valid),
    .flit_stall_o     (flit_stall),
    .flit_code_i      (flit_code),
    .flit_bits_i      (flit_bits),
    .res_valid_o      (res_valid),
    .res_stall_i      (res_stall),
    .write_valid_o    (write_valid),
    .write_target_o   (write_target),
    .write_address_o  (write_address),
    .write_data_o     (write_data),
    .weight_loaded_o  (weight_loaded),
    .bias_loaded_o    (bias_loaded),
    .input_complete_o (input_complete),
    .error_code_o     (error_code)
  );

  tb_fprs_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .flit_valid_i     (flit_valid),
    .flit_stall_i     (flit_stall),
    .flit_code_i      (flit_code),
    .flit_bits_i      (flit_bits),
    .res_valid_i      (res_valid),
    .res_stall_i      (res_stall),
    .write_valid_i    (write_valid),
    .write_target_i   (write_target),
    .write_address_i  (write_address),
    .write_data_i     (write_data),
    .weight_loaded_i  (weight_loaded),
    .bias_loaded_i    (bias_loaded),
    .input_complete_i (input_complete),
    .error_code_i     (error_code),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // Encode a non-negative value given in half steps as a float word.
  function automatic logic [31:0] float_of(input int unsigned twice);
    int p;
    if (twice == 0) return 32'h0;
    p = 31;
    while (twice[p] == 1'b0) p--;
    return {1'b0, 8'(p + 126), 23'(twice << (23 - p))};
  endfunction

  // Mostly a plain float of v, sometimes a word that hits a conversion corner.
  function automatic logic [31:0] index_word(input int unsigned v);
    case ($urandom_range(0, 15))
      0:       return 32'h7FC00000;  // NaN
      1:       return 32'hFF800000;  // -inf
      2:       return 32'h7F800000;  // +inf saturates
      3:       return 32'hC0400000;  // negative
      4:       return 32'h4A000000;  // 2^21 saturates
      5:       return 32'h00000001;  // denormal
      6:       return $urandom;
      default: return float_of(2 * v + $urandom_range(0, 1));
    endcase
  endfunction

  function automatic logic [31:0] head_word(input logic [3:0] ptype);
    logic [31:0] r;
    r = $urandom;
    return {r[31:28], ptype, r[23:0]};
  endfunction

  // Offer one flit beat and hold it until accepted.
  task automatic send_flit(input fprs_pkg::flit_code_e kind, input logic [31:0] bits);
    @(negedge clk);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      flit_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    flit_valid <= 1'b1;
    flit_code  <= kind;
    flit_bits  <= bits;
    @(posedge clk);
    while (flit_stall) @(posedge clk);
    if (kind != fprs_pkg::CODE_SKIP) flits_sent++;
  endtask

  task automatic flit_idle();
    @(negedge clk);
    flit_valid <= 1'b0;
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drain the core, then load all four registers.
  task automatic reconfigure(input bit flat, input int unsigned spatial,
                             input int unsigned tensor, input int unsigned chunks);
    flit_idle();
    wait (pending == 0);
    repeat (4) @(posedge clk);
    apb_write(fprs_pkg::REG_LAYOUT, flat);
    apb_write(fprs_pkg::REG_SPATIAL, spatial);
    apb_write(fprs_pkg::REG_TENSOR, tensor);
    apb_write(fprs_pkg::REG_EXPECTED, chunks);
    cur_flat    = flat;
    cur_spatial = spatial;
  endtask

  // Mostly well-formed packets; some noise, dropped tails and short results.
  task automatic send_random_packet();
    int          pick, nbody, span, start, cnt;
    logic [3:0]  ptype;
    logic [31:0] w;
    pick = $urandom_range(0, 19);
    if (pick == 19) begin
      repeat ($urandom_range(1, 4))
        send_flit(fprs_pkg::flit_code_e'($urandom_range(0, 3)), $urandom);
      return;
    end
    if (pick < 5)       ptype = fprs_pkg::PT_DATA;
    else if (pick < 9)  ptype = fprs_pkg::PT_WEIGHT;
    else if (pick < 12) ptype = fprs_pkg::PT_BIAS;
    else if (pick < 18) ptype = fprs_pkg::PT_RESULT;
    else                ptype = 4'($urandom_range(4, 15));
    send_flit(fprs_pkg::CODE_HEAD, head_word(ptype));
    start = $urandom_range(0, 12);
    cnt   = $urandom_range(0, 4);
    if (ptype != fprs_pkg::PT_RESULT) begin
      nbody = $urandom_range(0, 12);
    end else if ($urandom_range(0, 7) == 0) begin
      nbody = $urandom_range(0, 1);
    end else begin
      span  = cur_flat ? cnt : cnt * ((cur_spatial == 0) ? 1 : cur_spatial);
      span  = span + $urandom_range(0, 2);
      nbody = 2 + ((span > 40) ? 40 : span);
    end
    for (int i = 0; i < nbody; i++) begin
      if (ptype == fprs_pkg::PT_RESULT && i == 0)      w = index_word(start);
      else if (ptype == fprs_pkg::PT_RESULT && i == 1) w = index_word(cnt);
      else                                             w = $urandom;
      if ($urandom_range(0, 19) == 0) send_flit(fprs_pkg::CODE_SKIP, $urandom);
      send_flit(fprs_pkg::CODE_BODY, w);
    end
    // drop the tail now and then so the next head cuts the packet off
    if ($urandom_range(0, 9) != 0) send_flit(fprs_pkg::CODE_TAIL, $urandom);
  endtask

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin : receiver
    int burst;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long && !hold_done) begin
        res_stall <= 1'b1;
        repeat (80) @(negedge clk);
        hold_done = 1'b1;
        res_stall <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 10);
        res_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  // End the run when neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((flit_valid && !flit_stall) || (res_valid && !res_stall)) quiet = 0;
      else quiet++;
    end
    $display("** flit_packet_receive_and_scatter_core: FAILED **");
    $finish;
  end

  initial begin : stimulus
    bit          flat;
    int unsigned spatial, tensor, chunks;
    int          goal;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Stray bodies and tails with no open packet, and an ignored flit
    send_flit(fprs_pkg::CODE_BODY, 32'hFFFFFFFF);
    send_flit(fprs_pkg::CODE_TAIL, 32'h00000000);
    send_flit(fprs_pkg::CODE_SKIP, 32'hFFFFFFFF);

    // Zero spatial size and zero chunk threshold
    reconfigure(1'b0, 0, 16, 0);
    send_flit(fprs_pkg::CODE_HEAD, 32'hF0FFFFFF);
    send_flit(fprs_pkg::CODE_BODY, 32'hFFFFFFFF);
    send_flit(fprs_pkg::CODE_BODY, 32'h00000000);
    send_flit(fprs_pkg::CODE_TAIL, 32'h00000000);
    send_flit(fprs_pkg::CODE_HEAD, {4'h5, fprs_pkg::PT_WEIGHT, 24'h000000});
    send_flit(fprs_pkg::CODE_BODY, 32'hA5A5A5A5);
    send_flit(fprs_pkg::CODE_TAIL, 32'hFFFFFFFF);
    send_flit(fprs_pkg::CODE_HEAD, {4'h0, fprs_pkg::PT_BIAS, 24'h000001});
    send_flit(fprs_pkg::CODE_TAIL, 32'h00000000);
    // Result chunk at 2.0 with count 3.5: the fourth word runs past the count
    send_flit(fprs_pkg::CODE_HEAD, {4'h3, fprs_pkg::PT_RESULT, 24'h000010});
    send_flit(fprs_pkg::CODE_BODY, float_of(4));
    send_flit(fprs_pkg::CODE_BODY, float_of(7));
    repeat (4) send_flit(fprs_pkg::CODE_BODY, $urandom);
    send_flit(fprs_pkg::CODE_TAIL, 32'h00000000);
    // Unknown packet type
    send_flit(fprs_pkg::CODE_HEAD, {4'h9, 4'hF, 24'h000002});
    send_flit(fprs_pkg::CODE_BODY, 32'h12345678);
    send_flit(fprs_pkg::CODE_TAIL, 32'h00000000);
    // Head inside an open packet, then a short result packet
    send_flit(fprs_pkg::CODE_HEAD, {4'h1, fprs_pkg::PT_RESULT, 24'h000004});
    send_flit(fprs_pkg::CODE_HEAD, {4'h2, fprs_pkg::PT_DATA, 24'h000000});
    send_flit(fprs_pkg::CODE_TAIL, 32'h00000000);
    send_flit(fprs_pkg::CODE_HEAD, {4'h1, fprs_pkg::PT_RESULT, 24'h000001});
    send_flit(fprs_pkg::CODE_BODY, float_of(2));
    send_flit(fprs_pkg::CODE_TAIL, 32'h00000000);

    // Random packets over several register settings
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       begin flat = 1'b0; spatial = 4;     tensor = 64;      chunks = 2;   end
        1:       begin flat = 1'b1; spatial = 36;    tensor = 200;     chunks = 3;   end
        2:       begin flat = 1'b0; spatial = 1;     tensor = 1048576; chunks = 1;   end
        3:       begin flat = 1'b1; spatial = 65536; tensor = 0;       chunks = 256; end
        4:       begin flat = 1'b0; spatial = 65536; tensor = 1048576; chunks = 511; end
        5:       begin flat = 1'b0; spatial = 9;     tensor = 300;     chunks = 0;   end
        6:       begin flat = 1'b1; spatial = 1;     tensor = 50;      chunks = 4;   end
        default: begin flat = 1'b0; spatial = 3;     tensor = 120;     chunks = 2;   end
      endcase
      reconfigure(flat, spatial, tensor, chunks);
      // no idling in the last phase
      tx_idle = (phase != 7);
      rx_idle = (phase != 7);
      // hold the receiver while flits keep coming, so the input backs up
      if (phase == 2) hold_long = 1'b1;
      goal = flits_sent + PHASE_ITEMS;
      while (flits_sent < goal) send_random_packet();
    end

    flit_idle();
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("** flit_packet_receive_and_scatter_core: PASSED **");
    else
      $display("** flit_packet_receive_and_scatter_core: FAILED **");
    $finish;
  end

endmodule

FILE: files.f
hdl/fprs_pkg.sv
hdl/fprs_front.sv
hdl/fprs_queue.sv
hdl/fprs_back.sv
hdl/flit_packet_receive_and_scatter_core.sv
tb/sv/tb_fprs_checker.sv
tb/sv/tb_flit_packet_receive_and_scatter_core.sv
